FILE: design/binary_lifting_lca_defines.svh
// ----------------------------------------------------------------------------
// binary_lifting_lca_defines.svh
// Assertion macros for the binary lifting LCA block; empty bodies under SYNTH.
// ----------------------------------------------------------------------------
`ifndef BINARY_LIFTING_LCA_DEFINES_SVH
`define BINARY_LIFTING_LCA_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BLCA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLCA_ASSERT(lbl, ante, cons, msg)
`define BLCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/blca_pkg.sv
// ----------------------------------------------------------------------------
// blca_pkg
// Shared constants for the binary lifting LCA block.
// ----------------------------------------------------------------------------
`default_nettype none

package blca_pkg;

  // field width of node numbers and depths
  localparam int FIELD_W = 10;

  // default sizing
  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 11;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

FILE: design/blca_ram.sv
// ----------------------------------------------------------------------------
// blca_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module blca_ram #(
  parameter  int WIDTH = 10,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/binary_lifting_lca.sv
// Load: parent entry write and parent depth read, then one ancestor entry per cycle.
// Query: the single table read port paces it (a lift step that moves a waits
//   for its read; two reads per level in the joint lift).
// One transaction at a time; busy is high while a transaction is in work.
// A query result appears with done for one cycle; the receiver cannot stall.
// After rst the depth store is swept to zero, min(NODES,1024) rows, busy high.
// ----------------------------------------------------------------------------
// binary_lifting_lca
// Binary lifting ancestor table with depth store; loads nodes, answers LCA.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_lifting_lca_defines.svh"

module binary_lifting_lca
  import blca_pkg::*;
#(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command,
  input  wire logic [FIELD_W-1:0] node_a,
  input  wire logic [FIELD_W-1:0] node_b,
  output logic                    done,
  output logic      [FIELD_W-1:0] ancestor
);

  // sizing
  localparam int NROWS = (NODES > (1 << FIELD_W)) ? (1 << FIELD_W) : NODES;
  localparam int IW    = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int KW    = $clog2(LEVELS + 1);
  localparam int TDEP  = NROWS << LW;
  localparam int TAW   = IW + LW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE,
    S_LD_START, S_LD_DEPTH, S_LD_FILL,
    S_Q_DA, S_Q_DB, S_Q_SWAP, S_Q_LIFT, S_Q_LIFTW,
    S_Q_CHK, S_Q_RB, S_Q_CMP, S_Q_FIN
  } state_t;

  state_t            state;
  logic [IW-1:0]     clr;
  logic [IW-1:0]     a;
  logic [IW-1:0]     b;
  logic [IW-1:0]     ra;
  logic [KW-1:0]     k;
  logic [FIELD_W-1:0] d;
  logic [FIELD_W-1:0] depa;

  // memory ports
  logic              t_we;
  logic [TAW-1:0]    t_waddr;
  logic [IW-1:0]     t_wdata;
  logic [TAW-1:0]    t_raddr;
  logic [IW-1:0]     t_rdata;
  logic              d_we;
  logic [IW-1:0]     d_waddr;
  logic [FIELD_W-1:0] d_wdata;
  logic [IW-1:0]     d_raddr;
  logic [FIELD_W-1:0] d_rdata;

  // read-side fixups for the table
  logic              t_zero;
  logic              t_byp;
  logic [IW-1:0]     t_wdata_q;
  logic [IW-1:0]     tq;

  logic              accept;
  logic [IW-1:0]     in_a;
  logic [IW-1:0]     in_b;
  logic              lift_diff;
  logic [IW-1:0]     na;
  logic [IW-1:0]     nb;
  logic [KW-1:0]     k_m1;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // out-of-range node numbers fold onto the sentinel
  assign in_a = (32'(node_a) < 32'(NROWS)) ? node_a[IW-1:0] : '0;
  assign in_b = (32'(node_b) < 32'(NROWS)) ? node_b[IW-1:0] : '0;

  // sentinel row reads as zero; same-address write is forwarded
  assign tq = t_zero ? '0 : (t_byp ? t_wdata_q : t_rdata);

  assign lift_diff = (ra != tq);
  assign na        = lift_diff ? ra : a;
  assign nb        = lift_diff ? tq : b;
  assign k_m1      = k - 1'b1;

  // memory port control
  always_comb begin
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_raddr = '0;
    d_we    = 1'b0;
    d_waddr = '0;
    d_wdata = '0;
    d_raddr = '0;
    case (state)
      S_CLEAR: begin
        d_we    = 1'b1;
        d_waddr = clr;
      end
      S_LD_START: begin
        t_we    = 1'b1;
        t_waddr = {a, {LW{1'b0}}};
        t_wdata = b;
        d_raddr = b;
      end
      S_LD_DEPTH: begin
        d_we    = 1'b1;
        d_waddr = a;
        d_wdata = (b == '0) ? '0 : d_rdata + 1'b1;
        t_raddr = {b, {LW{1'b0}}};
      end
      S_LD_FILL: begin
        t_we    = 1'b1;
        t_waddr = {a, k[LW-1:0]};
        t_wdata = tq;
        t_raddr = {tq, k[LW-1:0]};
      end
      S_Q_DA: d_raddr = a;
      S_Q_DB: d_raddr = b;
      S_Q_LIFT: t_raddr = {a, k[LW-1:0]};
      S_Q_CHK: t_raddr = {a, LW'(LEVELS - 1)};
      S_Q_RB: t_raddr = {b, k[LW-1:0]};
      S_Q_CMP: t_raddr = (k == '0) ? {na, {LW{1'b0}}} : {na, k_m1[LW-1:0]};
      default: ;
    endcase
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    t_zero    <= (t_raddr[TAW-1:LW] == '0);
    t_byp     <= t_we && (t_waddr == t_raddr);
    t_wdata_q <= t_wdata;
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      // result strobe: early match at the check, or end of the joint lift
      done <= ((state == S_Q_CHK) && (a == b)) || (state == S_Q_FIN);
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == IW'(NROWS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            a <= in_a;
            b <= in_b;
            if (command == CMD_QUERY) state <= S_Q_DA;
            else if (in_a != '0)      state <= S_LD_START;
          end
        end
        S_LD_START: state <= S_LD_DEPTH;
        S_LD_DEPTH: begin
          k <= KW'(1);
          if (LEVELS == 1) state <= S_IDLE;
          else             state <= S_LD_FILL;
        end
        S_LD_FILL: begin
          k <= k + 1'b1;
          if (k == KW'(LEVELS - 1)) state <= S_IDLE;
        end
        S_Q_DA: state <= S_Q_DB;
        S_Q_DB: begin
          depa  <= d_rdata;
          state <= S_Q_SWAP;
        end
        // deeper node goes to a
        S_Q_SWAP: begin
          k <= '0;
          if (depa < d_rdata) begin
            a <= b;
            b <= a;
            d <= d_rdata - depa;
          end else begin
            d <= depa - d_rdata;
          end
          state <= S_Q_LIFT;
        end
        S_Q_LIFT: begin
          if (k == KW'(LEVELS) || d == '0) begin
            state <= S_Q_CHK;
          end else if (d[0]) begin
            state <= S_Q_LIFTW;
          end else begin
            d <= d >> 1;
            k <= k + 1'b1;
          end
        end
        S_Q_LIFTW: begin
          a     <= tq;
          d     <= d >> 1;
          k     <= k + 1'b1;
          state <= S_Q_LIFT;
        end
        S_Q_CHK: begin
          if (a == b) begin
            ancestor <= FIELD_W'(a);
            state    <= S_IDLE;
          end else begin
            k     <= KW'(LEVELS - 1);
            state <= S_Q_RB;
          end
        end
        S_Q_RB: begin
          ra    <= tq;
          state <= S_Q_CMP;
        end
        // joint lift while the two ancestors differ
        S_Q_CMP: begin
          a <= na;
          b <= nb;
          if (k == '0) begin
            state <= S_Q_FIN;
          end else begin
            k     <= k_m1;
            state <= S_Q_RB;
          end
        end
        S_Q_FIN: begin
          ancestor <= FIELD_W'(tq);
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  blca_ram #(
    .WIDTH(IW),
    .DEPTH(TDEP)
  ) u_table (
    .clk  (clk),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .raddr(t_raddr),
    .rdata(t_rdata)
  );

  blca_ram #(
    .WIDTH(FIELD_W),
    .DEPTH(NROWS)
  ) u_depth (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .raddr(d_raddr),
    .rdata(d_rdata)
  );

  // checks
  `BLCA_ASSERT(a_done_from_query, done, $past(state) == S_Q_FIN || $past(state) == S_Q_CHK, "result without query end")
  `BLCA_ASSERT_NEXT(a_query_busy, accept && command == CMD_QUERY, busy, "query transaction not taken")
  `BLCA_ASSERT(a_no_sentinel_write, t_we, t_waddr[TAW-1:LW] != '0, "sentinel row written")
  `BLCA_ASSERT(a_liftw_order, state == S_Q_LIFTW, $past(state) == S_Q_LIFT, "lift wait out of order")

endmodule

`default_nettype wire
